// ===== rtl/dacl_pkg.sv =====
// Shared types, constants and control structs for the DACL access checker.
// No dependencies; every other rtl file refers to this package by scoped name.
package dacl_pkg;

    localparam int TOKEN_SIDS = 16;
    localparam int MAX_ACES   = 64;

    localparam int SID_W  = 64;
    localparam int MASK_W = 32;

    localparam int TOK_CNT_W = $clog2(TOKEN_SIDS + 1);
    localparam int TOK_IDX_W = (TOKEN_SIDS > 1) ? $clog2(TOKEN_SIDS) : 1;
    localparam int ACE_CNT_W = $clog2(MAX_ACES + 1);
    localparam int ACE_IDX_W = (MAX_ACES > 1) ? $clog2(MAX_ACES) : 1;

    localparam logic [MASK_W-1:0] MASK_MAX_ALLOWED  = 32'h0200_0000;
    localparam logic [MASK_W-1:0] MASK_DELETE       = 32'h0001_0000;
    localparam logic [MASK_W-1:0] MASK_READ_CONTROL = 32'h0002_0000;
    localparam logic [MASK_W-1:0] MASK_WRITE_DAC    = 32'h0004_0000;
    localparam logic [MASK_W-1:0] MASK_OWNER        = MASK_WRITE_DAC | MASK_READ_CONTROL;
    localparam int                MAX_ALLOWED_BIT   = 25;

    typedef enum logic [1:0] {
        REQ_ADD_SID = 2'd0,
        REQ_ADD_ACE = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_ALLOWED    = 2'd0,
        KIND_DENIED     = 2'd1,
        KIND_DENIED_OBJ = 2'd2,
        KIND_OTHER      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DENIED = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic               inherit_only;
        logic [MASK_W-1:0]  mask;
        logic [SID_W-1:0]   trustee;
    } t_ace;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_PASS1,
        S_EXPAND,
        S_PASS2,
        S_FINISH
    } t_state;

    typedef enum logic {
        PASS_GRANT,
        PASS_CHECK
    } t_pass;

    // controller -> datapath
    typedef struct packed {
        logic  latch;
        logic  prep;
        logic  load;
        logic  pass_init;
        logic  pass_run;
        t_pass pass_sel;
        logic  expand;
        logic  finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_check;
        logic need_pass1;
        logic need_pass2;
        logic pass_done;
    } t_dp_sts;

endpackage

// ===== rtl/dacl_ctrl.sv =====
// Sequencer for the DACL checker: decode, load, up to two ACE walks, finish.
// Depends on dacl_pkg for state, command and status types.
module dacl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dacl_pkg::t_dp_sts i_sts,
    output dacl_pkg::t_dp_cmd o_cmd,
    output logic              busy
);

    dacl_pkg::t_state r_state;
    dacl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dacl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dacl_pkg::S_IDLE: begin
                if (start) n_state = dacl_pkg::S_DECODE;
            end
            dacl_pkg::S_DECODE: begin
                if (!i_sts.is_check)       n_state = dacl_pkg::S_LOAD;
                else if (i_sts.need_pass1) n_state = dacl_pkg::S_PASS1;
                else                       n_state = dacl_pkg::S_EXPAND;
            end
            dacl_pkg::S_LOAD: begin
                n_state = dacl_pkg::S_IDLE;
            end
            dacl_pkg::S_PASS1: begin
                if (i_sts.pass_done) n_state = dacl_pkg::S_EXPAND;
            end
            dacl_pkg::S_EXPAND: begin
                n_state = i_sts.need_pass2 ? dacl_pkg::S_PASS2 : dacl_pkg::S_FINISH;
            end
            dacl_pkg::S_PASS2: begin
                if (i_sts.pass_done) n_state = dacl_pkg::S_FINISH;
            end
            dacl_pkg::S_FINISH: begin
                n_state = dacl_pkg::S_IDLE;
            end
            default: n_state = dacl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.pass_sel = dacl_pkg::PASS_GRANT;
        busy           = 1'b1;
        unique case (r_state)
            dacl_pkg::S_IDLE: begin
                busy        = 1'b0;
                o_cmd.latch = start;
            end
            dacl_pkg::S_DECODE: begin
                o_cmd.prep      = 1'b1;
                o_cmd.pass_init = 1'b1;
            end
            dacl_pkg::S_LOAD: begin
                o_cmd.load   = 1'b1;
                o_cmd.finish = 1'b1;
            end
            dacl_pkg::S_PASS1: begin
                o_cmd.pass_run = 1'b1;
            end
            dacl_pkg::S_EXPAND: begin
                o_cmd.expand    = 1'b1;
                o_cmd.pass_init = 1'b1;
            end
            dacl_pkg::S_PASS2: begin
                o_cmd.pass_run = 1'b1;
                o_cmd.pass_sel = dacl_pkg::PASS_CHECK;
            end
            dacl_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/dacl_dp.sv =====
// Datapath: token registers, ACE table memory, walk pipeline, mask logic.
// Depends on dacl_pkg; driven by dacl_ctrl through t_dp_cmd.
module dacl_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_req_type,
    input  logic [dacl_pkg::SID_W-1:0]   i_sid_value,
    input  logic [1:0]                   i_ace_kind,
    input  logic                         i_inherit_only,
    input  logic [dacl_pkg::MASK_W-1:0]  i_access_mask,
    input  logic                         i_dacl_present,
    input  dacl_pkg::t_dp_cmd            i_cmd,
    output dacl_pkg::t_dp_sts            o_sts,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [dacl_pkg::MASK_W-1:0]  o_granted_mask
);

    // latched request
    dacl_pkg::t_req                r_req;
    logic [dacl_pkg::SID_W-1:0]    r_sid;
    dacl_pkg::t_kind               r_kind;
    logic                          r_inh;
    logic [dacl_pkg::MASK_W-1:0]   r_mask;
    logic                          r_dacl;

    // stores
    logic [dacl_pkg::SID_W-1:0]     r_tok [dacl_pkg::TOKEN_SIDS];
    logic [dacl_pkg::TOK_CNT_W-1:0] r_tok_cnt;
    dacl_pkg::t_ace                 ace_mem [dacl_pkg::MAX_ACES];
    logic [dacl_pkg::ACE_CNT_W-1:0] r_ace_cnt;

    // walk
    logic [dacl_pkg::ACE_CNT_W-1:0] r_idx;
    logic                           r_q_vld;
    dacl_pkg::t_ace                 r_ace_q;

    // check
    logic                          r_owner_hit;
    logic [dacl_pkg::MASK_W-1:0]   r_grant;
    logic [dacl_pkg::MASK_W-1:0]   r_deny;
    logic [dacl_pkg::MASK_W-1:0]   r_desired;
    logic [dacl_pkg::MASK_W-1:0]   r_remaining;
    logic                          r_denied;

    // result
    logic                          r_valid;
    dacl_pkg::t_status             r_status;
    logic [dacl_pkg::MASK_W-1:0]   r_granted;

    logic                          tok_full;
    logic                          ace_full;
    logic                          owner_match;
    logic                          trustee_match;
    logic                          ace_apply;
    logic                          ace_is_deny;
    logic [dacl_pkg::MASK_W-1:0]   max_bits;
    logic [dacl_pkg::MASK_W-1:0]   exp_desired;
    logic [dacl_pkg::MASK_W-1:0]   exp_remaining;
    dacl_pkg::t_status             fin_status;
    logic [dacl_pkg::MASK_W-1:0]   fin_granted;

    function automatic logic tok_hit(input logic [dacl_pkg::SID_W-1:0] sid);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < dacl_pkg::TOKEN_SIDS; i++) begin
            if ((dacl_pkg::TOK_CNT_W'(i) < r_tok_cnt) && (r_tok[i] == sid)) hit = 1'b1;
        end
        return hit;
    endfunction

    // token lookups also follow token writes, not just the compared SID
    always_comb begin
        owner_match   = tok_hit(r_sid);
        trustee_match = tok_hit(r_ace_q.trustee);
    end

    assign tok_full      = (r_tok_cnt == dacl_pkg::TOK_CNT_W'(dacl_pkg::TOKEN_SIDS));
    assign ace_full      = (r_ace_cnt == dacl_pkg::ACE_CNT_W'(dacl_pkg::MAX_ACES));
    assign ace_apply     = i_cmd.pass_run && r_q_vld && !r_ace_q.inherit_only && trustee_match;
    assign ace_is_deny   = (r_ace_q.kind == dacl_pkg::KIND_DENIED) ||
                           (r_ace_q.kind == dacl_pkg::KIND_DENIED_OBJ);

    // maximum-allowed expansion; deny can strip even the owner and delete bits
    always_comb begin
        max_bits = (dacl_pkg::MASK_DELETE | (r_owner_hit ? dacl_pkg::MASK_OWNER : '0) | r_grant)
                   & ~r_deny;
        if (r_mask[dacl_pkg::MAX_ALLOWED_BIT]) begin
            exp_desired   = (r_mask | max_bits) & ~dacl_pkg::MASK_MAX_ALLOWED;
            exp_remaining = exp_desired & ~dacl_pkg::MASK_DELETE;
        end else begin
            exp_desired   = r_mask;
            exp_remaining = r_mask;
        end
        if (r_owner_hit) exp_remaining = exp_remaining & ~dacl_pkg::MASK_OWNER;
    end

    always_comb begin
        fin_status  = dacl_pkg::ST_OK;
        fin_granted = '0;
        unique case (r_req)
            dacl_pkg::REQ_ADD_SID: begin
                if (tok_full) fin_status = dacl_pkg::ST_FULL;
            end
            dacl_pkg::REQ_ADD_ACE: begin
                if (ace_full) fin_status = dacl_pkg::ST_FULL;
            end
            dacl_pkg::REQ_CHECK: begin
                priority if (!r_dacl) begin
                    fin_granted = r_desired;
                end else if (r_ace_cnt == '0 || r_denied || r_remaining != '0) begin
                    fin_status = dacl_pkg::ST_DENIED;
                end else begin
                    fin_granted = r_desired;
                end
            end
            dacl_pkg::REQ_CLEAR: begin
                fin_status = dacl_pkg::ST_OK;
            end
            default: fin_status = dacl_pkg::ST_OK;
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= dacl_pkg::t_req'(i_req_type);
            r_sid  <= i_sid_value;
            r_kind <= dacl_pkg::t_kind'(i_ace_kind);
            r_inh  <= i_inherit_only;
            r_mask <= i_access_mask;
            r_dacl <= i_dacl_present;
        end
    end

    // token and table counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_cnt <= '0;
            r_ace_cnt <= '0;
        end else if (i_cmd.load) begin
            unique case (r_req)
                dacl_pkg::REQ_ADD_SID: begin
                    if (!tok_full) r_tok_cnt <= r_tok_cnt + 1'b1;
                end
                dacl_pkg::REQ_ADD_ACE: begin
                    if (!ace_full) r_ace_cnt <= r_ace_cnt + 1'b1;
                end
                dacl_pkg::REQ_CLEAR: begin
                    r_tok_cnt <= '0;
                    r_ace_cnt <= '0;
                end
                dacl_pkg::REQ_CHECK: begin
                    r_tok_cnt <= r_tok_cnt;
                end
                default: r_tok_cnt <= r_tok_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_req == dacl_pkg::REQ_ADD_SID && !tok_full) begin
            r_tok[r_tok_cnt[dacl_pkg::TOK_IDX_W-1:0]] <= r_sid;
        end
    end

    // ACE table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_req == dacl_pkg::REQ_ADD_ACE && !ace_full) begin
            ace_mem[r_ace_cnt[dacl_pkg::ACE_IDX_W-1:0]] <= '{kind: r_kind,
                inherit_only: r_inh, mask: r_mask, trustee: r_sid};
        end
        if (i_cmd.pass_run) r_ace_q <= ace_mem[r_idx[dacl_pkg::ACE_IDX_W-1:0]];
    end

    // walk pointer: address issue runs one entry ahead of evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_q_vld <= 1'b0;
        end else if (i_cmd.pass_init) begin
            r_idx   <= '0;
            r_q_vld <= 1'b0;
        end else if (i_cmd.pass_run) begin
            if (r_idx < r_ace_cnt) begin
                r_idx   <= r_idx + 1'b1;
                r_q_vld <= 1'b1;
            end else begin
                r_q_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_owner_hit <= owner_match;
            r_grant     <= '0;
            r_deny      <= '0;
            r_denied    <= 1'b0;
        end
        if (i_cmd.expand) begin
            r_desired   <= exp_desired;
            r_remaining <= exp_remaining;
        end
        if (ace_apply) begin
            if (i_cmd.pass_sel == dacl_pkg::PASS_GRANT) begin
                if (r_ace_q.kind == dacl_pkg::KIND_ALLOWED) begin
                    r_grant <= r_grant | r_ace_q.mask;
                end else if (ace_is_deny) begin
                    r_deny <= r_deny | r_ace_q.mask;
                end
            end else begin
                if (r_ace_q.kind == dacl_pkg::KIND_ALLOWED) begin
                    r_remaining <= r_remaining & ~r_ace_q.mask;
                end else if (ace_is_deny && (r_remaining & r_ace_q.mask) != '0) begin
                    r_denied <= 1'b1;
                end
            end
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status  <= fin_status;
            r_granted <= fin_granted;
        end
    end

    assign o_sts.is_check   = (r_req == dacl_pkg::REQ_CHECK);
    assign o_sts.need_pass1 = r_mask[dacl_pkg::MAX_ALLOWED_BIT] && r_dacl;
    assign o_sts.need_pass2 = r_dacl;
    assign o_sts.pass_done  = (r_idx == r_ace_cnt) && !r_q_vld;

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_granted_mask = r_granted;

endmodule

// ===== rtl/dacl_access_check.sv =====
// Top level of the DACL access checker: controller plus datapath.
// Depends on dacl_pkg, dacl_ctrl and dacl_dp.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low; its
//   kind (add token SID, add ACE, run check, clear) and fields are sampled
//   at that edge only. Every request gives exactly one response: o_valid is
//   high for one cycle with o_status and o_granted_mask. The receiver cannot
//   stall; the response must be captured in that cycle.
// Sequencing (N = stored ACEs):
//   Loads and clear: decode, then load, which also raises the response.
//   Check without DACL: decode, expand, finish.
//   Check with DACL: decode, expand, a walk of the N ACEs that resolves the
//   desired bits, then finish; a first walk that collects grants comes before
//   expand when the maximum-allowed bit (bit 25) is set. One ACE per cycle
//   through the registered read port; trustees are compared against all token
//   SIDs in parallel. A new request can be taken at the edge that takes the
//   response, since busy is already low while o_valid is high.
// Reset:
//   Synchronous, active low; empties token and table (counts to zero) and
//   returns the sequencer to idle. Stored SIDs and ACEs are not cleared.
module dacl_access_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic [dacl_pkg::SID_W-1:0]   i_sid_value,
    input  logic [1:0]                   i_ace_kind,
    input  logic                         i_inherit_only,
    input  logic [dacl_pkg::MASK_W-1:0]  i_access_mask,
    input  logic                         i_dacl_present,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [dacl_pkg::MASK_W-1:0]  o_granted_mask
);

    dacl_pkg::t_dp_cmd cmd;
    dacl_pkg::t_dp_sts sts;

    // sequencer: one request in flight at a time
    dacl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // storage, ACE walk and mask evaluation
    dacl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_sid_value    (i_sid_value),
        .i_ace_kind     (i_ace_kind),
        .i_inherit_only (i_inherit_only),
        .i_access_mask  (i_access_mask),
        .i_dacl_present (i_dacl_present),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted_mask (o_granted_mask)
    );

endmodule
